### rtl/core/bqps_pkg.sv
// Shared types, codes and widths of the byte queue with pattern search.
package bqps_pkg;

  // Default sizes
  localparam int CAPACITY_DEF    = 1024;
  localparam int MAX_PATTERN_DEF = 8;

  // Field widths
  localparam int OPCODE_W  = 3;
  localparam int DATA_W    = 8;
  localparam int POS_W     = 10;
  localparam int FILL_W    = 11;
  localparam int CFG_W     = 64;
  localparam int PLEN_W    = 4;
  localparam int CFG_IDX_W = 1;

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_FLUSH  = 3'd4
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_READ   = 3'b010,
    ST_SEARCH = 3'b100
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic load_imm;
    logic load_read;
    logic search_start;
    logic search_run;
    logic load_search;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;
    logic search_viable;
    logic search_hit;
    logic search_end;
  } dp_status_t;

endpackage

### rtl/core/bqps_if.sv
// Request, result and configuration channel interfaces of the byte queue.
interface bqps_in_if;
  logic                             valid;
  logic                             ready;
  logic [bqps_pkg::OPCODE_W-1:0]    opcode;
  logic [bqps_pkg::DATA_W-1:0]      data_in;
  logic [bqps_pkg::POS_W-1:0]       position;

  modport source (output valid, output opcode, output data_in, output position, input ready);
  modport sink   (input valid, input opcode, input data_in, input position, output ready);
endinterface

interface bqps_out_if;
  logic                             valid;
  logic                             ready;
  logic [bqps_pkg::DATA_W-1:0]      data_out;
  logic                             data_valid;
  logic                             found;
  logic [bqps_pkg::POS_W-1:0]       match_index;
  logic [bqps_pkg::FILL_W-1:0]      fill_level;
  logic                             overflow;

  modport source (output valid, output data_out, output data_valid, output found,
                  output match_index, output fill_level, output overflow, input ready);
  modport sink   (input valid, input data_out, input data_valid, input found,
                  input match_index, input fill_level, input overflow, output ready);
endinterface

interface bqps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bqps_pkg::CFG_IDX_W-1:0]   index;
  logic [bqps_pkg::CFG_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/bqps_ctrl.sv
// Controller state machine of the byte queue: sequences requests and searches.
module bqps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bqps_in_if.sink                in_if,
  input  bqps_pkg::dp_status_t   status_i,
  output bqps_pkg::ctrl_cmd_t    cmd_o
);
  import bqps_pkg::*;

  state_e state_q, state_d;
  logic   ready_c;

  // Decide commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ready_c = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        ready_c      = !status_i.out_busy;
        cmd_o.accept = in_if.valid && ready_c;
        if (cmd_o.accept) begin
          unique case (in_if.opcode) inside
            OP_POP, OP_PEEK: begin
              state_d = ST_READ;
            end
            OP_SEARCH: begin
              if (status_i.search_viable) begin
                cmd_o.search_start = 1'b1;
                state_d            = ST_SEARCH;
              end else begin
                cmd_o.load_imm = 1'b1;
              end
            end
            default: begin
              cmd_o.load_imm = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.load_read = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SEARCH: begin
        cmd_o.search_run = 1'b1;
        if (status_i.search_hit || status_i.search_end) begin
          cmd_o.load_search = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_if.ready = ready_c;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/bqps_dp.sv
// Datapath of the byte queue: byte store, pointers, search window and result register.
module bqps_dp #(
  parameter int CAPACITY    = bqps_pkg::CAPACITY_DEF,
  parameter int MAX_PATTERN = bqps_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bqps_pkg::ctrl_cmd_t             cmd_i,
  input  logic [bqps_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [bqps_pkg::DATA_W-1:0]     data_in_i,
  input  logic [bqps_pkg::POS_W-1:0]      position_i,
  bqps_cfg_if.sink                        cfg_if,
  bqps_out_if.source                      out_if,
  output bqps_pkg::dp_status_t            status_o
);
  import bqps_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > FILL_W) ? CW : FILL_W;
  localparam int WIW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [AW:0]       CAP_A   = (AW + 1)'(CAPACITY);
  localparam logic [CW-1:0]     CAP_C   = CW'(CAPACITY);
  localparam logic [PLEN_W-1:0] MAXP    = PLEN_W'(MAX_PATTERN);

  // Store and pointers
  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] rdata_q;
  logic              rd_ok_q, rd_ok_d;

  // Configuration
  logic [CFG_W-1:0]  pat_q;
  logic [PLEN_W-1:0] plen_q;
  logic [PLEN_W-1:0] eff_len;

  // Compare helpers
  logic              full, empty, peek_ok, viable;
  logic [CMPW-1:0]   count_x, pos_x, len_x, fill_x;

  // Search walk
  logic [CW-1:0]     soff_q, soff_d;
  logic              sread;
  logic              sv_q, wv_q;
  logic [AW-1:0]     stag_q, wtag_q;
  logic [DATA_W-1:0] win_q [MAX_PATTERN];
  logic [PLEN_W-1:0] wfill_q, wfill_d;
  logic              win_match, hit, send;
  logic [AW-1:0]     mstart;
  logic [CMPW-1:0]   mstart_x;

  // Result register
  logic              out_valid_q, out_valid_d, do_load;
  logic [DATA_W-1:0] data_out_q, data_out_d;
  logic              data_valid_q, data_valid_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  match_q, match_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;

  // Circular address: both operands below capacity
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CAP_A) begin
      s = s - CAP_A;
    end
    return s[AW-1:0];
  endfunction

  // Write configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= PLEN_W'(1);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_PATTERN_BYTES:  pat_q  <= cfg_if.data;
        REG_PATTERN_LENGTH: plen_q <= cfg_if.data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp pattern length to one through the maximum
  always_comb begin
    if (plen_q == '0) begin
      eff_len = PLEN_W'(1);
    end else if (plen_q > MAXP) begin
      eff_len = MAXP;
    end else begin
      eff_len = plen_q;
    end
  end

  assign full    = (count_q == CAP_C);
  assign empty   = (count_q == '0);
  assign count_x = CMPW'(count_q);
  assign pos_x   = CMPW'(position_i);
  assign len_x   = CMPW'(eff_len);
  assign peek_ok = (pos_x < count_x);
  assign viable  = (len_x <= count_x) && (pos_x <= count_x - len_x);
  assign sread   = cmd_i.search_run && (soff_q < count_q);

  // Update pointers and drive store ports
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = wrap_add(head_q, count_q[AW-1:0]);
    rd_en   = 1'b0;
    rd_addr = head_q;
    rd_ok_d = rd_ok_q;
    soff_d  = soff_q;
    if (cmd_i.accept) begin
      unique case (opcode_i)
        OP_PUSH: begin
          if (!full) begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        OP_POP: begin
          rd_en   = 1'b1;
          rd_ok_d = !empty;
          if (!empty) begin
            count_d = count_q - CW'(1);
            head_d  = (count_q == CW'(1)) ? '0 : wrap_add(head_q, AW'(1));
          end
        end
        OP_PEEK: begin
          rd_en   = 1'b1;
          rd_addr = wrap_add(head_q, pos_x[AW-1:0]);
          rd_ok_d = peek_ok;
        end
        OP_SEARCH: begin
          soff_d = pos_x[CW-1:0];
        end
        OP_FLUSH: begin
          head_d  = '0;
          count_d = '0;
        end
        default: ;
      endcase
    end else if (sread) begin
      rd_en   = 1'b1;
      rd_addr = wrap_add(head_q, soff_q[AW-1:0]);
      soff_d  = soff_q + CW'(1);
    end
  end

  // Byte store write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= data_in_i;
    end
  end

  // Byte store read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Hold pointers and search control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      soff_q  <= '0;
      sv_q    <= 1'b0;
      wv_q    <= 1'b0;
      wfill_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      soff_q  <= soff_d;
      sv_q    <= sread;
      wv_q    <= cmd_i.search_run && sv_q;
      wfill_q <= wfill_d;
    end
  end

  // Count bytes in the window, saturating at the maximum pattern
  always_comb begin
    wfill_d = wfill_q;
    if (cmd_i.search_start) begin
      wfill_d = '0;
    end else if (cmd_i.search_run && sv_q && (wfill_q < MAXP)) begin
      wfill_d = wfill_q + PLEN_W'(1);
    end
  end

  // Shift read bytes into the window, newest at entry zero
  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_ok_d;
    if (sread) begin
      stag_q <= soff_q[AW-1:0];
    end
    if (cmd_i.search_run && sv_q) begin
      win_q[0] <= rdata_q;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        win_q[i] <= win_q[i-1];
      end
      wtag_q <= stag_q;
    end
  end

  // Compare window against the pattern, first pattern byte oldest
  always_comb begin
    int li;
    win_match = 1'b1;
    li        = 0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < int'(eff_len)) begin
        li = int'(eff_len) - 1 - k;
        if (win_q[WIW'(li)] != pat_q[DATA_W*k +: DATA_W]) begin
          win_match = 1'b0;
        end
      end
    end
  end

  assign hit      = cmd_i.search_run && wv_q && (wfill_q >= eff_len) && win_match;
  assign send     = (soff_q == count_q) && !sv_q && !wv_q;
  assign mstart   = wtag_q - AW'(eff_len) + AW'(1);
  assign mstart_x = CMPW'(mstart);
  assign fill_x   = CMPW'(count_d);

  // Select the result
  always_comb begin
    data_out_d   = data_out_q;
    data_valid_d = data_valid_q;
    found_d      = found_q;
    match_d      = match_q;
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    do_load      = cmd_i.load_imm || cmd_i.load_read || cmd_i.load_search;
    if (do_load) begin
      data_out_d   = '0;
      data_valid_d = 1'b0;
      found_d      = 1'b0;
      match_d      = '0;
      fill_d       = fill_x[FILL_W-1:0];
      ovf_d        = 1'b0;
    end
    if (cmd_i.load_imm) begin
      ovf_d = (opcode_i == OP_PUSH) && full;
    end
    if (cmd_i.load_read) begin
      data_out_d   = rd_ok_q ? rdata_q : '0;
      data_valid_d = rd_ok_q;
    end
    if (cmd_i.load_search && hit) begin
      found_d = 1'b1;
      match_d = mstart_x[POS_W-1:0];
    end
    if (do_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Hold result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    data_out_q   <= data_out_d;
    data_valid_q <= data_valid_d;
    found_q      <= found_d;
    match_q      <= match_d;
    fill_q       <= fill_d;
    ovf_q        <= ovf_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.data_out    = data_out_q;
  assign out_if.data_valid  = data_valid_q;
  assign out_if.found       = found_q;
  assign out_if.match_index = match_q;
  assign out_if.fill_level  = fill_q;
  assign out_if.overflow    = ovf_q;

  assign status_o.out_busy      = out_valid_q && !out_if.ready;
  assign status_o.search_viable = viable;
  assign status_o.search_hit    = hit;
  assign status_o.search_end    = send;

endmodule

### rtl/core/byte_queue_with_pattern_search.sv
// Push, flush, unused codes and searches that cannot match: result registered in the next cycle.
// Pop and peek: the byte passes the store's registered read port, then the result register.
// Search: one store byte read per cycle from the start offset until a match or the queue end.
// Requests are taken while a finished result waits, unless that result stalls.
// Reset clears head pointer, byte count, pattern bytes and sets pattern length to one;
// store contents are not cleared and need no clearing pass.
module byte_queue_with_pattern_search #(
  parameter int CAPACITY    = bqps_pkg::CAPACITY_DEF,
  parameter int MAX_PATTERN = bqps_pkg::MAX_PATTERN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bqps_in_if.sink     in_if,
  bqps_out_if.source  out_if,
  bqps_cfg_if.sink    cfg_if
);
  import bqps_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence requests
  bqps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Store, search and result
  bqps_dp #(
    .CAPACITY    (CAPACITY),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .opcode_i   (in_if.opcode),
    .data_in_i  (in_if.data_in),
    .position_i (in_if.position),
    .cfg_if     (cfg_if),
    .out_if     (out_if),
    .status_o   (status)
  );

`ifndef SYNTHESIS
  // No new request while a read or a search is in flight
  a_accept_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !cmd.load_read && !cmd.search_run)
    else $error("request accepted during read or search");

  // A read result follows the request that issued it
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_read |-> $past(cmd.accept))
    else $error("read result without request");

  // A started search walks the store in the next cycle
  a_search_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.search_start |=> cmd.search_run)
    else $error("search started but not running");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench of the byte queue with pattern search, with its own predictor.
module tb;
  import bqps_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int PAT_MAX      = MAX_PATTERN_DEF;
  localparam int SHALLOW_FILL = 48;
  localparam int TAIL_CYCLES  = 16;
  // The timeout leaves room for full-store searches with stalls.
  localparam int TIMEOUT_UNITS = 20_000_000;

  // Opcodes the block must treat as no operation
  localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   data;
    logic [POS_W-1:0]    pos;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              found;
    logic [POS_W-1:0]  match_index;
    logic [FILL_W-1:0] fill_level;
    logic              overflow;
  } res_t;

  typedef struct packed {
    req_t req;
    logic has_exp;
    res_t exp;
  } row_t;

  logic clk_i;
  logic rst_ni;

  bqps_in_if  in_if ();
  bqps_out_if out_if ();
  bqps_cfg_if cfg_if ();

  byte_queue_with_pattern_search u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Shadow copy of the queue and its pattern registers
  logic [DATA_W-1:0] mirror_store [CAP];
  int                mirror_head;
  int                mirror_count;
  logic [CFG_W-1:0]  mirror_pattern;
  logic [PLEN_W-1:0] mirror_plen;

  res_t pending_replies [$];
  row_t dir_rows [$];
  int   errors;
  int   n_requests;
  int   n_replies;
  int   n_found;
  int   n_overflow;
  int   n_cfg_writes;
  int   tx_gap_pct;
  int   rx_stall_pct;

  // Generate the clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // End a hung run
  initial begin
    #(TIMEOUT_UNITS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit roll(int pct);
    return int'($urandom_range(0, 99)) < pct;
  endfunction

  // Effective pattern length: zero counts as one, saturate at the maximum
  function automatic int active_len();
    int len;
    len = int'(mirror_plen);
    if (len == 0) len = 1;
    if (len > PAT_MAX) len = PAT_MAX;
    return len;
  endfunction

  function automatic req_t mk_req(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] d,
                                  logic [POS_W-1:0] p);
    req_t r;
    r.opcode = op;
    r.data   = d;
    r.pos    = p;
    return r;
  endfunction

  function automatic res_t known_reply(logic [DATA_W-1:0] d, logic dv, logic f,
                                       logic [POS_W-1:0] mi, logic [FILL_W-1:0] fill,
                                       logic ov);
    res_t r;
    r.data_out    = d;
    r.data_valid  = dv;
    r.found       = f;
    r.match_index = mi;
    r.fill_level  = fill;
    r.overflow    = ov;
    return r;
  endfunction

  function automatic row_t dir_row(req_t r, logic has_exp, res_t exp);
    row_t row;
    row.req     = r;
    row.has_exp = has_exp;
    row.exp     = exp;
    return row;
  endfunction

  // Apply one request to the shadow queue and return the reply it must give
  function automatic res_t predict_byte_op(req_t r);
    res_t res;
    int   len;
    int   s;
    int   k;
    bit   hit;
    res = '0;
    case (r.opcode)
      OP_PUSH: begin
        if (mirror_count >= CAP) begin
          res.overflow = 1'b1;
        end else begin
          mirror_store[(mirror_head + mirror_count) % CAP] = r.data;
          mirror_count++;
        end
      end
      OP_POP: begin
        if (mirror_count > 0) begin
          res.data_out   = mirror_store[mirror_head];
          res.data_valid = 1'b1;
          mirror_count--;
          mirror_head = (mirror_count == 0) ? 0 : (mirror_head + 1) % CAP;
        end
      end
      OP_PEEK: begin
        if (int'(r.pos) < mirror_count) begin
          res.data_out   = mirror_store[(mirror_head + int'(r.pos)) % CAP];
          res.data_valid = 1'b1;
        end
      end
      OP_SEARCH: begin
        len = active_len();
        for (s = int'(r.pos); s + len <= mirror_count && !res.found; s++) begin
          hit = 1'b1;
          for (k = 0; k < len; k++) begin
            if (mirror_store[(mirror_head + s + k) % CAP] != mirror_pattern[8*k +: 8]) hit = 1'b0;
          end
          if (hit) begin
            res.found       = 1'b1;
            res.match_index = POS_W'(s);
          end
        end
      end
      OP_FLUSH: begin
        mirror_head  = 0;
        mirror_count = 0;
      end
      default: begin
      end
    endcase
    res.fill_level = FILL_W'(mirror_count);
    return res;
  endfunction

  // Half random bytes, half bytes taken from the pattern so searches hit
  function automatic logic [DATA_W-1:0] pick_byte();
    if (roll(50)) return DATA_W'($urandom_range(0, 255));
    return mirror_pattern[8*$urandom_range(0, PAT_MAX-1) +: 8];
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (roll(20)) return POS_W'($urandom_range(0, CAP-1));
    return POS_W'($urandom_range(0, mirror_count));
  endfunction

  // Send one request; keep valid high afterwards unless a gap follows
  task automatic send_req(req_t r, logic has_exp, res_t exp);
    res_t pred;
    if (roll(tx_gap_pct)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while (roll(tx_gap_pct)) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.opcode   <= r.opcode;
    in_if.data_in  <= r.data;
    in_if.position <= r.pos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pred = predict_byte_op(r);
    pending_replies.push_back(has_exp ? exp : pred);
    n_requests++;
  endtask

  // Drop valid and wait until every reply is back
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write both pattern registers back to back; the block must be idle
  task automatic write_pattern(logic [CFG_W-1:0] bytes, logic [PLEN_W-1:0] len);
    logic [CFG_W-1:0] len_word;
    len_word = {$urandom(), $urandom()};
    len_word[PLEN_W-1:0] = len;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_PATTERN_BYTES;
    cfg_if.data  <= bytes;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    mirror_pattern = bytes;
    cfg_if.index <= REG_PATTERN_LENGTH;
    cfg_if.data  <= len_word;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    mirror_plen = len_word[PLEN_W-1:0];
    cfg_if.valid <= 1'b0;
    n_cfg_writes += 2;
  endtask

  // Push the active pattern, optionally with one byte spoiled
  task automatic push_pattern_run(bit spoil);
    int               len;
    int               bad;
    logic [DATA_W-1:0] d;
    len = active_len();
    bad = $urandom_range(0, len-1);
    for (int k = 0; k < len; k++) begin
      d = mirror_pattern[8*k +: 8];
      if (spoil && k == bad) d = d ^ DATA_W'(1 << $urandom_range(0, DATA_W-1));
      send_req(mk_req(OP_PUSH, d, POS_W'($urandom_range(0, CAP-1))), 1'b0, '0);
    end
  endtask

  // Random traffic: pattern runs followed by searches, mixed with single requests of every opcode
  task automatic play_random(int n_items, int fill_cap, bit pressure);
    int   left;
    int   pick;
    req_t r;
    left = n_items;
    while (left > 0) begin
      if (pressure && $urandom_range(0, 19) == 0) settle();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        push_pattern_run(pick < 3);
        send_req(mk_req(OP_SEARCH, pick_byte(), pick_pos()), 1'b0, '0);
        left -= active_len() + 1;
      end else begin
        if (pick < 42) begin
          r = mk_req(OP_PUSH, pick_byte(), POS_W'($urandom_range(0, CAP-1)));
          if (mirror_count >= fill_cap && fill_cap < CAP) r.opcode = OP_POP;
        end else if (pick < 62) begin
          r = mk_req(OP_POP, pick_byte(), POS_W'($urandom_range(0, CAP-1)));
        end else if (pick < 74) begin
          r = mk_req(OP_PEEK, pick_byte(), pick_pos());
        end else if (pick < 92) begin
          r = mk_req(OP_SEARCH, pick_byte(), pick_pos());
        end else if (pick < 95) begin
          r = mk_req(OP_FLUSH, pick_byte(), pick_pos());
        end else begin
          r = mk_req(OPCODE_W'($urandom_range(OP_SPARE_A, OP_SPARE_C)),
                     DATA_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, CAP-1)));
        end
        send_req(r, 1'b0, '0);
        left--;
      end
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Stall the reply channel at random
  always @(posedge clk_i) begin
    out_if.ready <= !roll(rx_stall_pct);
  end

  // Compare each reply with the oldest pending one
  always @(posedge clk_i) begin : reply_check
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_replies++;
      if (out_if.found) n_found++;
      if (out_if.overflow) n_overflow++;
      if (pending_replies.size() == 0) begin
        $error("reply with no request pending");
        errors++;
      end else begin
        want = pending_replies.pop_front();
        check_field("data_out", want.data_out, out_if.data_out);
        check_field("data_valid", want.data_valid, out_if.data_valid);
        check_field("found", want.found, out_if.found);
        check_field("match_index", want.match_index, out_if.match_index);
        check_field("fill_level", want.fill_level, out_if.fill_level);
        check_field("overflow", want.overflow, out_if.overflow);
      end
    end
  end

  initial begin : stimulus
    res_t zero_reply;
    errors       = 0;
    n_requests   = 0;
    n_replies    = 0;
    n_found      = 0;
    n_overflow   = 0;
    n_cfg_writes = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    zero_reply   = '0;

    // Hold every input at a known value through reset
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.opcode    = OP_PUSH;
    in_if.data_in   = '0;
    in_if.position  = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_PATTERN_BYTES;
    cfg_if.data     = '0;
    mirror_head     = 0;
    mirror_count    = 0;
    mirror_pattern  = '0;
    mirror_plen     = PLEN_W'(1);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests on the reset pattern: a single zero byte
    dir_rows.push_back(dir_row(mk_req(OP_POP, 8'h00, 10'h000), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_PEEK, 8'h00, 10'h000), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_SEARCH, 8'h00, 10'h000), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_FLUSH, 8'hFF, 10'h3FF), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_SPARE_A, 8'hFF, 10'h3FF), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_SPARE_B, 8'hFF, 10'h3FF), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_SPARE_C, 8'h00, 10'h000), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_PUSH, 8'h00, 10'h000), 1'b1,
                               known_reply(8'h00, 1'b0, 1'b0, 10'd0, 11'd1, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_SEARCH, 8'h00, 10'h000), 1'b1,
                               known_reply(8'h00, 1'b0, 1'b1, 10'd0, 11'd1, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_SEARCH, 8'h00, 10'h3FF), 1'b1,
                               known_reply(8'h00, 1'b0, 1'b0, 10'd0, 11'd1, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_PUSH, 8'hFF, 10'h3FF), 1'b1,
                               known_reply(8'h00, 1'b0, 1'b0, 10'd0, 11'd2, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_PEEK, 8'h00, 10'h001), 1'b1,
                               known_reply(8'hFF, 1'b1, 1'b0, 10'd0, 11'd2, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_PEEK, 8'h00, 10'h002), 1'b1,
                               known_reply(8'h00, 1'b0, 1'b0, 10'd0, 11'd2, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_PEEK, 8'h00, 10'h3FF), 1'b1,
                               known_reply(8'h00, 1'b0, 1'b0, 10'd0, 11'd2, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_POP, 8'h00, 10'h000), 1'b1,
                               known_reply(8'h00, 1'b1, 1'b0, 10'd0, 11'd1, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_SEARCH, 8'h00, 10'h000), 1'b1,
                               known_reply(8'h00, 1'b0, 1'b0, 10'd0, 11'd1, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_POP, 8'h00, 10'h000), 1'b1,
                               known_reply(8'hFF, 1'b1, 1'b0, 10'd0, 11'd0, 1'b0)));
    dir_rows.push_back(dir_row(mk_req(OP_POP, 8'h00, 10'h000), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_PUSH, 8'hA5, 10'h155), 1'b0, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_PUSH, 8'h5A, 10'h2AA), 1'b0, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_PUSH, 8'h00, 10'h000), 1'b0, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_SEARCH, 8'h00, 10'h000), 1'b0, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_SEARCH, 8'h00, 10'h003), 1'b0, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_PEEK, 8'h00, 10'h002), 1'b0, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_FLUSH, 8'h00, 10'h000), 1'b1, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_PUSH, 8'h7E, 10'h000), 1'b0, zero_reply));
    dir_rows.push_back(dir_row(mk_req(OP_POP, 8'h00, 10'h000), 1'b0, zero_reply));
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
    settle();

    // One-byte pattern, no idling
    write_pattern({$urandom(), $urandom()}, PLEN_W'(1));
    play_random(16, SHALLOW_FILL, 1'b0);
    settle();

    // All-zero pattern with length zero, sender idling, pauses until drained
    tx_gap_pct = 56;
    write_pattern('0, PLEN_W'(0));
    play_random(16, SHALLOW_FILL, 1'b1);
    settle();

    // All-ones pattern with oversized length, receiver stalling
    tx_gap_pct   = 0;
    rx_stall_pct = 56;
    write_pattern('1, '1);
    play_random(16, SHALLOW_FILL, 1'b0);
    settle();

    // Full-length pattern, both sides idling
    tx_gap_pct   = 25;
    rx_stall_pct = 25;
    write_pattern({$urandom(), $urandom()}, PLEN_W'(PAT_MAX));
    play_random(16, SHALLOW_FILL, 1'b0);
    settle();

    // Mid-length pattern, no idling
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    write_pattern({$urandom(), $urandom()}, PLEN_W'($urandom_range(2, PAT_MAX-1)));
    play_random(16, SHALLOW_FILL, 1'b0);
    settle();

    // Fill to capacity, overflow, then wrap the head around the store
    rx_stall_pct = 56;
    write_pattern({$urandom(), $urandom()}, PLEN_W'(4));
    while (mirror_count < CAP) begin
      if ($urandom_range(0, 31) == 0 && mirror_count + PAT_MAX <= CAP) begin
        push_pattern_run(1'b0);
      end else begin
        send_req(mk_req(OP_PUSH, pick_byte(), POS_W'($urandom_range(0, CAP-1))),
                 1'b0, zero_reply);
      end
    end
    repeat (3) send_req(mk_req(OP_PUSH, DATA_W'($urandom_range(0, 255)), 10'h3FF),
                        1'b0, zero_reply);
    send_req(mk_req(OP_PEEK, 8'h00, 10'h3FF), 1'b0, zero_reply);
    send_req(mk_req(OP_SEARCH, 8'h00, 10'h000), 1'b0, zero_reply);
    send_req(mk_req(OP_SEARCH, 8'h00, POS_W'(CAP - PAT_MAX)), 1'b0, zero_reply);
    send_req(mk_req(OP_SEARCH, 8'h00, 10'h3FF), 1'b0, zero_reply);
    repeat (24) send_req(mk_req(OP_POP, 8'h00, 10'h000), 1'b0, zero_reply);
    repeat (24) send_req(mk_req(OP_PUSH, pick_byte(), 10'h000), 1'b0, zero_reply);
    repeat (4) send_req(mk_req(OP_SEARCH, 8'h00, POS_W'($urandom_range(0, CAP-1))),
                        1'b0, zero_reply);
    repeat (8) send_req(mk_req(OP_PEEK, 8'h00, POS_W'($urandom_range(0, CAP-1))),
                        1'b0, zero_reply);
    play_random(24, CAP, 1'b0);
    send_req(mk_req(OP_FLUSH, 8'h00, 10'h000), 1'b0, zero_reply);
    settle();

    // Random pattern length over the whole register range, sender idling
    tx_gap_pct   = 56;
    rx_stall_pct = 0;
    write_pattern({$urandom(), $urandom()}, PLEN_W'($urandom_range(0, 15)));
    play_random(16, SHALLOW_FILL, 1'b0);
    settle();

    // Three-byte pattern, both sides idling
    tx_gap_pct   = 25;
    rx_stall_pct = 25;
    write_pattern({$urandom(), $urandom()}, PLEN_W'(3));
    play_random(16, SHALLOW_FILL, 1'b0);
    settle();

    $display("Run covered %0d requests and %0d replies: %0d pattern hits, %0d dropped pushes.",
             n_requests, n_replies, n_found, n_overflow);
    $display("Pattern registers written %0d times; one pass filled the store and wrapped it.",
             n_cfg_writes);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
